[hw/rtl/assert_macros.svh]
// assertion helpers, clocked on clk with rst_n low masking
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wsg_pkg.sv]
package wsg_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int STAIR_LEVELS   = 10;
  localparam int STAIR_HALF     = (STAIR_LEVELS - 1) / 2;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam int DVD_W     = 64;
  localparam int DVS_W     = 48;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int MAG_W     = 32;
  localparam int MUL_CNT_W = $clog2(MAG_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [47:0] ONE_Q = 48'(64'd1 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FRAC    = 3'd5;

  localparam logic [2:0] WAVE_CONST  = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_STAIR  = 3'd3;
  localparam logic [2:0] WAVE_SINE   = 3'd4;
  localparam logic [2:0] WAVE_TRI    = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REM,
    ST_NORM,
    ST_PREP,
    ST_ROM,
    ST_MUL,
    ST_QUOT,
    ST_DIV,
    ST_COMB,
    ST_FIN
  } state_t;

endpackage

[hw/rtl/wsg_divider.sv]
module wsg_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wsg_pkg::DVD_W-1:0]  dividend,
  input  logic [wsg_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [wsg_pkg::DVD_W-1:0]  quotient,
  output logic [wsg_pkg::DVS_W-1:0]  remainder
);
  import wsg_pkg::*;

  logic [DVD_W-1:0]     quo_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       diff;
  logic                 take;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign take    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1)) && !start;
      if (start) begin
        cnt_r <= DIV_CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DVD_W-2:0], take};
      rem_r <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/wsg_cos_rom.sv]
module wsg_cos_rom #(
  parameter int SINE_TABLE_DEPTH = wsg_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr,
  output logic [wsg_pkg::FRAC_BITS:0]           data
);
  import wsg_pkg::*;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam int TaylorTerms = 12;
  localparam longint unsigned TaylorDiv [TaylorTerms] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  // quarter-wave cosine, taylor series in q30
  function automatic logic [FRAC_BITS:0] cos_entry(input longint unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned rounded;
    x    = (HalfPiQ30 * idx) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int k = 1; k <= TaylorTerms; k++) begin
      term = ((term * x2) >> 30) / TaylorDiv[k-1];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    rounded = (longint'(unsigned'(sum)) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return rounded[FRAC_BITS:0];
  endfunction

  logic [FRAC_BITS:0] rom [SINE_TABLE_DEPTH+1];
  logic [FRAC_BITS:0] data_r;

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = cos_entry(64'(g));
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

  assign data = data_r;

endmodule

[hw/rtl/waveform_sample_generator_top.sv]
// waveform sample generator: one sample beat per tick beat
// per tick: constant skips all; square phase wrap and normalize; sawtooth phase wrap, shift-add
// multiply by the level span and final scale; triangle wrap, normalize and multiply; sine
// also a cosine rom read; stairstep wrap, normalize, multiply and final scale; the divides
// are bit-serial; next tick taken in the cycle after the sample is registered
// rst_n synchronous active low: levels 0, period 100.0, duty 0.5, start and phase cleared
module waveform_sample_generator_top #(
  parameter int SINE_TABLE_DEPTH = wsg_pkg::SINE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_sample_value,
  output logic                               out_divide_fault,
  input  logic                               cfg_we,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wsg_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TW = $clog2(4 * SINE_TABLE_DEPTH);

  // config
  logic [2:0]         waveform_r;
  logic signed [31:0] level_first_r;
  logic signed [31:0] level_second_r;
  logic [47:0]        period_len_r;
  logic [47:0]        start_phase_r;
  logic [16:0]        duty_frac_r;

  state_t state_r, state_nxt;

  logic [47:0]          phase_acc_r;
  logic [47:0]          ph_r;
  logic [47:0]          php_mag_r;
  logic                 php_neg_r;
  logic [51:0]          n_r;
  logic [47:0]          m_r;
  logic [53:0]          a_r;
  logic                 a_neg_r;
  logic [61:0]          acc_r;
  logic                 sticky_r;
  logic [MAG_W-1:0]     b_r;
  logic [MUL_CNT_W-1:0] mul_cnt_r;
  logic [62:0]          q_r;
  logic [31:0]          res_r;
  logic                 fault_r;
  logic                 out_valid_r;
  logic [31:0]          out_value_r;
  logic                 out_fault_r;

  logic is_const, wave_saw, wave_stair, wave_sine, wave_tri, wave_square;
  logic [47:0] p_eff;
  logic        ph_neg;
  logic [47:0] ph_mag;
  logic [48:0] nxt;
  logic        nxt_neg;
  logic [47:0] nxt_mag;
  logic [49:0] php;
  logic [47:0] php_mag;
  logic [32:0] ptp;
  logic        ptp_neg;
  logic [31:0] ptp_mag;
  logic        frac_le;
  logic [47:0] m_val;
  logic [51:0] qn;
  logic [51:0] n_val;
  logic [51:0] n_abs;
  logic [53:0] tri_d;
  logic [63:0] mul_sum;
  logic [62:0] p_val;
  logic        out_free;

  logic [FRAC_BITS-1:0]    fr;
  logic [1:0]              quad;
  logic [FRAC_BITS+TW-1:0] t_full;
  logic [TW-1:0]           t_idx;
  logic [TW-1:0]           j_idx;
  logic [AW-1:0]           rom_addr;
  logic [FRAC_BITS:0]      rom_data;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  logic        sub_q;
  logic [31:0] base;
  logic [64:0] wide;
  logic [31:0] sat_val;

  wsg_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  wsg_cos_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    is_const    = !(waveform_r inside {[WAVE_SQUARE:WAVE_TRI]});
    wave_square = waveform_r == WAVE_SQUARE;
    wave_saw    = waveform_r == WAVE_SAW;
    wave_stair  = waveform_r == WAVE_STAIR;
    wave_sine   = waveform_r == WAVE_SINE;
    wave_tri    = waveform_r == WAVE_TRI;
  end

  // phase terms
  always_comb begin
    p_eff   = (period_len_r < ONE_Q) ? ONE_Q : period_len_r;
    ph_neg  = ph_r[47];
    ph_mag  = ph_neg ? (48'(0) - ph_r) : ph_r;
    nxt     = {ph_r[47], ph_r} + {1'b0, ONE_Q};
    nxt_neg = nxt[48];
    nxt_mag = nxt_neg ? 48'(49'(0) - nxt) : nxt[47:0];
    php     = ph_neg ? ({{2{ph_r[47]}}, ph_r} + {2'b0, p_eff}) : {{2{ph_r[47]}}, ph_r};
    php_mag = php[49] ? 48'(50'(0) - php) : php[47:0];
    ptp     = {level_second_r[31], level_second_r} - {level_first_r[31], level_first_r};
    ptp_neg = ptp[32];
    ptp_mag = ptp_neg ? 32'(33'(0) - ptp) : ptp[31:0];
    frac_le = ph_neg ? ((p_eff[FRAC_BITS-1:0] == '0) && (ph_mag[FRAC_BITS-1:0] == '0))
                     : (p_eff[FRAC_BITS-1:0] <= ph_mag[FRAC_BITS-1:0]);
    m_val   = 48'(p_eff[47:FRAC_BITS]) - 48'(frac_le);
    qn      = div_quo[51:0] + 52'(php_neg_r && (div_rem != '0));
    n_val   = php_neg_r ? (52'(0) - qn) : qn;
    n_abs   = n_r[51] ? (52'(0) - n_r) : n_r;
    tri_d   = {6'b0, ONE_Q} - {n_r[51], n_r, 1'b0};
    mul_sum = {1'b0, acc_r, 1'b0} + (b_r[MAG_W-1] ? 64'(a_r) : 64'(0));
    p_val   = sticky_r ? (63'(1) << 62) : {1'b0, acc_r};
  end

  // cosine table address from the normalized phase fraction
  always_comb begin
    fr       = n_r[FRAC_BITS-1:0];
    quad     = fr[FRAC_BITS-1 -: 2];
    t_full   = (FRAC_BITS+TW)'(fr) * (FRAC_BITS+TW)'(4 * SINE_TABLE_DEPTH);
    t_idx    = t_full[FRAC_BITS +: TW];
    j_idx    = t_idx - TW'(quad) * TW'(SINE_TABLE_DEPTH);
    rom_addr = quad[0] ? (AW'(SINE_TABLE_DEPTH) - AW'(j_idx)) : AW'(j_idx);
  end

  // final combine and saturate
  always_comb begin
    sub_q = (a_neg_r ^ ptp_neg) ^ (wave_saw || wave_stair);
    base  = (wave_saw || wave_stair) ? level_second_r : level_first_r;
    wide  = sub_q ? ({{33{base[31]}}, base} - {2'b0, q_r})
                  : ({{33{base[31]}}, base} + {2'b0, q_r});
    if (!wide[64] && (wide[63:31] != '0)) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (wide[64] && (wide[63:31] != '1)) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = wide[31:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (is_const) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(nxt_mag);
          div_dvs   = p_eff;
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        if (div_done) begin
          if (wave_saw) begin
            state_nxt = ST_PREP;
          end else begin
            div_start = 1'b1;
            div_dvd   = wave_stair ? (64'(php_mag_r) * 64'(STAIR_LEVELS))
                                   : (64'(php_mag_r) << FRAC_BITS);
            div_dvs   = p_eff;
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (div_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (wave_square || (wave_saw && (m_val == '0))) begin
          state_nxt = ST_FIN;
        end else if (wave_sine) begin
          state_nxt = ST_ROM;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_ROM: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt_r == MUL_CNT_W'(1)) begin
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (wave_saw || wave_stair) begin
          div_start = 1'b1;
          div_dvd   = wave_saw ? (64'(p_val) + 64'(m_r >> 1)) : (64'(p_val) + 64'(STAIR_HALF));
          div_dvs   = wave_saw ? m_r : DVS_W'(STAIR_LEVELS - 1);
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_COMB;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_COMB;
        end
      end
      ST_COMB: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // config, phase, handshake and multiply counter control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r     <= WAVE_CONST;
      level_first_r  <= '0;
      level_second_r <= '0;
      period_len_r   <= 48'(100) << FRAC_BITS;
      start_phase_r  <= '0;
      duty_frac_r    <= 17'(1) << (FRAC_BITS - 1);
      phase_acc_r    <= '0;
      out_valid_r    <= 1'b0;
      mul_cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAVEFORM:     waveform_r     <= cfg_data[2:0];
          CFG_LEVEL_FIRST:  level_first_r  <= cfg_data[31:0];
          CFG_LEVEL_SECOND: level_second_r <= cfg_data[31:0];
          CFG_PERIOD_LEN:   period_len_r   <= cfg_data[47:0];
          CFG_START_PHASE:  start_phase_r  <= cfg_data[47:0];
          CFG_DUTY_FRAC:    duty_frac_r    <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (state_r == ST_LOAD && is_const) begin
        phase_acc_r <= ph_r;
      end else if (state_r == ST_REM && div_done) begin
        phase_acc_r <= nxt_neg ? (48'(0) - div_rem) : div_rem;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PREP) begin
        mul_cnt_r <= MUL_CNT_W'(MAG_W);
      end else if (state_r == ST_MUL) begin
        mul_cnt_r <= mul_cnt_r - MUL_CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      ph_r <= in_restart ? start_phase_r : phase_acc_r;
    end
    if (state_r == ST_LOAD) begin
      php_mag_r <= php_mag;
      php_neg_r <= php[49];
      res_r     <= level_first_r;
      fault_r   <= 1'b0;
    end
    if (state_r == ST_NORM && div_done) begin
      n_r <= n_val;
    end
    if (state_r == ST_PREP) begin
      m_r      <= m_val;
      acc_r    <= '0;
      sticky_r <= 1'b0;
      b_r      <= ptp_mag;
      if (wave_square) begin
        res_r <= ($signed(n_r) < $signed({35'b0, duty_frac_r})) ? level_first_r
                                                                 : level_second_r;
      end else if (wave_saw) begin
        a_r     <= 54'(ph_mag[47:FRAC_BITS]);
        a_neg_r <= ph_neg;
        if (m_val == '0) begin
          res_r   <= level_second_r;
          fault_r <= 1'b1;
        end
      end else if (wave_stair) begin
        a_r     <= {2'b0, n_abs};
        a_neg_r <= n_r[51];
      end else begin
        a_r     <= tri_d[53] ? (54'(0) - tri_d) : tri_d;
        a_neg_r <= 1'b0;
      end
    end
    if (state_r == ST_ROM) begin
      a_r     <= (quad[1] ^ quad[0]) ? (54'(ONE_Q) - 54'(rom_data))
                                     : (54'(ONE_Q) + 54'(rom_data));
      a_neg_r <= 1'b0;
    end
    // msb-first shift-add, clamped at 2^62
    if (state_r == ST_MUL) begin
      acc_r    <= mul_sum[61:0];
      sticky_r <= sticky_r || (mul_sum[63:62] != 2'b00);
      b_r      <= {b_r[MAG_W-2:0], 1'b0};
    end
    if (state_r == ST_QUOT) begin
      if (wave_sine) begin
        q_r <= 63'((64'(p_val) + (64'(1) << FRAC_BITS)) >> (FRAC_BITS + 1));
      end else begin
        q_r <= 63'((64'(p_val) + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      end
    end
    if (state_r == ST_DIV && div_done) begin
      q_r <= div_quo[62:0];
    end
    if (state_r == ST_COMB) begin
      res_r <= sat_val;
    end
    if (state_r == ST_FIN && out_free) begin
      out_value_r <= res_r;
      out_fault_r <= fault_r;
    end
  end

  assign in_ready         = state_r == ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_divide_fault = out_fault_r;

  `include "assert_macros.svh"

  `WSG_ASSERT_NEXT(a_accept_load, in_valid && in_ready, state_r == ST_LOAD, "accepted beat did not start")
  `WSG_ASSERT_IMPL(a_done_wait, div_done, state_r == ST_REM || state_r == ST_NORM || state_r == ST_DIV, "divider done outside a wait state")
  `WSG_ASSERT_IMPL(a_fault_saw, out_valid && out_divide_fault, waveform_r == WAVE_SAW, "fault on a non-sawtooth sample")
  `WSG_ASSERT_IMPL(a_mul_count, state_r == ST_MUL, mul_cnt_r != '0, "multiply ran past its count")

endmodule

[tb/sv/waveform_sample_generator_checker.sv]
`timescale 1ns / 1ps

module waveform_sample_generator_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_restart,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [31:0]             out_sample_value,
  input  logic                           out_divide_fault,
  input  logic                           cfg_we,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             err_count,
  output int                             pending
);
  import wsg_pkg::*;

  localparam int ROM_DEPTH = 1024;
  localparam longint unsigned QONE = 64'd65536;
  localparam longint unsigned PROD_CAP = 64'd1 << 62;
  localparam longint unsigned NORM_CAP = 64'd1 << 60;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               divide_fault;
  } sample_t;

  sample_t expected_samples[$];

  logic [2:0]  wave_sel;
  logic [31:0] lvl_first;
  logic [31:0] lvl_second;
  logic [47:0] period_q;
  logic [47:0] start_q;
  logic [16:0] duty_q;
  logic [47:0] phase_q;

  int err_total = 0;

  int unsigned cos_table[ROM_DEPTH+1];

  initial begin
    longint unsigned x, x2, term;
    longint sum;
    for (int i = 0; i <= ROM_DEPTH; i++) begin
      x = (64'd1686629713 * i) / ROM_DEPTH;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      cos_table[i] = int'((longint'(sum) + (64'd1 << 13)) >> 14);
    end
  end

  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint scaled_mul(longint a, longint b);
    longint unsigned ua, ub, p;
    ua = magn(a);
    ub = magn(b);
    if (ua != 0 && ub > PROD_CAP / ua) p = PROD_CAP;
    else p = ua * ub;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint round_div(longint v, longint unsigned d);
    longint unsigned q;
    q = (magn(v) + d / 2) / d;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint norm_div(longint num, longint unsigned den, int sh);
    longint unsigned a, q, r;
    a = magn(num);
    q = a / den;
    r = a % den;
    if (q >= NORM_CAP) return num < 0 ? -longint'(NORM_CAP) : longint'(NORM_CAP);
    for (int i = 0; i < sh; i++) begin
      if (q >= (NORM_CAP >> 1)) return num < 0 ? -longint'(NORM_CAP) : longint'(NORM_CAP);
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    if (num < 0) begin
      if (r != 0) q++;
      return -longint'(q);
    end
    return longint'(q);
  endfunction

  function automatic longint cosine_at(longint n);
    longint unsigned fr, t, quad, j;
    fr = n & (QONE - 1);
    t = (fr * 4 * ROM_DEPTH) >> 16;
    quad = t / ROM_DEPTH;
    j = t % ROM_DEPTH;
    case (quad)
      0: return longint'(cos_table[j]);
      1: return -longint'(cos_table[ROM_DEPTH - j]);
      2: return -longint'(cos_table[j]);
      default: return longint'(cos_table[ROM_DEPTH - j]);
    endcase
  endfunction

  function automatic sample_t next_sample(logic restart);
    sample_t s;
    longint v1, v2, r, ph, ptp, php, nxt, n, ip, fph, fpr, k;
    longint unsigned per, rem, ipr, m;
    v1 = longint'($signed(lvl_first));
    v2 = longint'($signed(lvl_second));
    s.divide_fault = 1'b0;
    if (restart) phase_q = start_q;
    if (wave_sel == WAVE_CONST || wave_sel > WAVE_TRI) begin
      r = v1;
    end else begin
      per = period_q < QONE ? QONE : longint'(period_q);
      ph = longint'($signed(phase_q));
      ptp = v2 - v1;
      php = ph < 0 ? ph + longint'(per) : ph;
      nxt = ph + longint'(QONE);
      rem = magn(nxt) % per;
      phase_q = 48'(nxt < 0 ? 64'd0 - rem : rem);
      case (wave_sel)
        WAVE_SQUARE: begin
          n = norm_div(php, per, 16);
          r = (n < longint'(duty_q)) ? v1 : v2;
        end
        WAVE_SAW: begin
          ip = longint'(magn(ph) >> 16);
          if (ph < 0) ip = -ip;
          fph = ph - ip * longint'(QONE);
          ipr = per >> 16;
          fpr = longint'(per & (QONE - 1));
          m = (fpr <= fph) ? ipr - 1 : ipr;
          if (m == 0) begin
            r = v2;
            s.divide_fault = 1'b1;
          end else begin
            r = v2 - round_div(scaled_mul(ip, ptp), m);
          end
        end
        WAVE_STAIR: begin
          k = norm_div(php * STAIR_LEVELS, per, 0);
          r = v2 - round_div(scaled_mul(k, ptp), STAIR_LEVELS - 1);
        end
        WAVE_SINE: begin
          n = norm_div(php, per, 16);
          r = v1 + round_div(scaled_mul(longint'(QONE) + cosine_at(n), ptp), 2 * QONE);
        end
        default: begin
          n = norm_div(php, per, 16);
          r = v1 + round_div(scaled_mul(longint'(magn(longint'(QONE) - 2 * n)), ptp), QONE);
        end
      endcase
    end
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    s.sample_value = r[31:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_total++;
  endtask

  assign pending   = expected_samples.size();
  assign err_count = err_total;

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      wave_sel   <= WAVE_CONST;
      lvl_first  <= '0;
      lvl_second <= '0;
      period_q   <= 48'd6553600;
      start_q    <= '0;
      duty_q     <= 17'd32768;
      phase_q    = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAVEFORM:     wave_sel   <= cfg_data[2:0];
          CFG_LEVEL_FIRST:  lvl_first  <= cfg_data[31:0];
          CFG_LEVEL_SECOND: lvl_second <= cfg_data[31:0];
          CFG_PERIOD_LEN:   period_q   <= cfg_data[47:0];
          CFG_START_PHASE:  start_q    <= cfg_data[47:0];
          CFG_DUTY_FRAC:    duty_q     <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_samples = {expected_samples, next_sample(in_restart)};
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample beat", out_sample_value, 0);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_value !== want.sample_value)
            report_mismatch("sample_value", out_sample_value, want.sample_value);
          if (out_divide_fault !== want.divide_fault)
            report_mismatch("divide_fault", out_divide_fault, want.divide_fault);
        end
      end
    end
  end

endmodule

[tb/sv/waveform_sample_generator_top_tb.sv]
`timescale 1ns / 1ps

module waveform_sample_generator_top_tb;
  import wsg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_sample_value;
  logic out_divide_fault;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int err_count;
  int pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT = 20000;

  always #1 clk = ~clk;

  waveform_sample_generator_top i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_restart, .out_valid, .out_ready,
    .out_sample_value, .out_divide_fault, .cfg_we, .cfg_index, .cfg_data
  );

  waveform_sample_generator_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_restart, .out_valid, .out_ready,
    .out_sample_value, .out_divide_fault, .cfg_we, .cfg_index, .cfg_data,
    .err_count, .pending
  );

  // receiver, with a long hold-off on request to back up the input
  always @(negedge clk) begin
    if (hold_req > 0 && hold_cnt == 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic program_gen(logic [2:0] w, logic [31:0] lf, logic [31:0] ls,
                             logic [47:0] per, logic [47:0] sp, logic [16:0] duty);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    @(negedge clk);
    write_reg(CFG_WAVEFORM, 48'(w));
    write_reg(CFG_LEVEL_FIRST, 48'(lf));
    write_reg(CFG_LEVEL_SECOND, 48'(ls));
    write_reg(CFG_PERIOD_LEN, per);
    write_reg(CFG_START_PHASE, sp);
    write_reg(CFG_DUTY_FRAC, 48'(duty));
    cfg_we <= 1'b0;
  endtask

  // called with time at a falling edge; returns at the accepting rising edge
  task automatic send_tick(logic rs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick_period();
    case ($urandom_range(7))
      0: return 48'($urandom_range(0, 65535));
      1: return 48'({$urandom, $urandom});
      2: return 48'hffff_ffff_ffff;
      3: return 48'd65536;
      default: return 48'($urandom_range(65536, 40 << 16));
    endcase
  endfunction

  function automatic logic [47:0] pick_phase();
    case ($urandom_range(5))
      0: return 48'h8000_0000_0000;
      1: return 48'h7fff_ffff_ffff;
      2: return 48'({$urandom, $urandom});
      default: return 48'(longint'($urandom_range(0, 80 << 16)) - (40 << 16));
    endcase
  endfunction

  initial begin
    logic [2:0] w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_tick(1'b0);
    send_tick(1'b0);
    for (int d = 0; d < 8; d++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      program_gen(3'(d), (d % 2) ? 32'h8000_0000 : 32'hfffb_0000,
                  (d % 2) ? 32'h7fff_ffff : 32'h0005_0000,
                  (d == 2) ? 48'd65536 : ((d == 1) ? 48'd100 : 48'h3_8000),
                  (d == 5) ? 48'h8000_0000_0000 : 48'hffff_ffff_0000,
                  (d == 1) ? 17'd65536 : 17'h1ffff);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
    end
    for (int p = 0; p < 24; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      @(negedge clk);
      in_valid <= 1'b0;
      w = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 5));
      program_gen(w, pick_level(), pick_level(), pick_period(), pick_phase(),
                  ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)));
      if (p == 6) hold_req = 600;
      for (int i = 0; i < 23; i++) send_tick($urandom_range(9) == 0);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/wsg_pkg.sv
hw/rtl/wsg_divider.sv
hw/rtl/wsg_cos_rom.sv
hw/rtl/waveform_sample_generator_top.sv
tb/sv/waveform_sample_generator_checker.sv
tb/sv/waveform_sample_generator_top_tb.sv
